FILE: hdl/gsc_pkg.sv
package gsc_pkg;

    localparam int unsigned TAG_W   = 16;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned GRACE_W = 8;

    localparam logic [GRACE_W-1:0] GRACE_RESET = 8'd4;
    localparam logic [GRACE_W-1:0] GRACE_MIN   = 8'd1;
    localparam logic [GRACE_W-1:0] GRACE_MAX   = 8'd60;
    localparam logic [TIME_W-1:0]  RENOTIFY_SECS = 32'd1;

    typedef enum logic [1:0] {
        KIND_SHUTDOWN = 2'd0,
        KIND_CANCEL   = 2'd1,
        KIND_UNKNOWN  = 2'd2,
        KIND_TICK     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CODE_SUCCESS   = 2'd0,
        CODE_IGNORED   = 2'd1,
        CODE_ABORTED   = 2'd2,
        CODE_NOT_FOUND = 2'd3
    } t_code;

    typedef struct packed {
        logic               reply_valid;
        logic [TAG_W-1:0]   reply_tag;
        logic [1:0]         reply_code;
        logic               count_valid;
        logic [COUNT_W-1:0] straggler_count;
        logic               send_break;
        logic               go_down;
        logic               forced_flag;
        logic               request_pending;
        logic               openers_blocked;
        logic               last;
    } t_result;

    typedef struct packed {
        logic    push0;
        logic    push1;
        t_result res0;
        t_result res1;
    } t_push;

    // wrapping signed compare: now is at or after t
    function automatic logic time_passed(input logic [TIME_W-1:0] now,
                                         input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] diff;
        diff = now - t;
        return ~diff[TIME_W-1];
    endfunction

    function automatic logic [TIME_W-1:0] clamp_grace(input logic [GRACE_W-1:0] raw);
        logic [GRACE_W-1:0] g;
        g = raw;
        if (g < GRACE_MIN) g = GRACE_MIN;
        if (g > GRACE_MAX) g = GRACE_MAX;
        return {{(TIME_W-GRACE_W){1'b0}}, g};
    endfunction

endpackage

FILE: hdl/gsc_item_if.sv
interface gsc_item_if;
    import gsc_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [TAG_W-1:0]   request_tag;
    logic [TAG_W-1:0]   target_tag;
    logic               want_count;
    logic [COUNT_W-1:0] open_count;
    logic [TIME_W-1:0]  now_seconds;

    modport source (
        output valid, kind, request_tag, target_tag, want_count, open_count, now_seconds,
        input  ready
    );

    modport sink (
        input  valid, kind, request_tag, target_tag, want_count, open_count, now_seconds,
        output ready
    );
endinterface

FILE: hdl/gsc_result_if.sv
interface gsc_result_if;
    import gsc_pkg::*;

    logic               valid;
    logic               ready;
    logic               reply_valid;
    logic [TAG_W-1:0]   reply_tag;
    logic [1:0]         reply_code;
    logic               count_valid;
    logic [COUNT_W-1:0] straggler_count;
    logic               send_break;
    logic               go_down;
    logic               forced_flag;
    logic               request_pending;
    logic               openers_blocked;
    logic               last;

    modport source (
        output valid, reply_valid, reply_tag, reply_code, count_valid, straggler_count,
               send_break, go_down, forced_flag, request_pending, openers_blocked, last,
        input  ready
    );

    modport sink (
        input  valid, reply_valid, reply_tag, reply_code, count_valid, straggler_count,
               send_break, go_down, forced_flag, request_pending, openers_blocked, last,
        output ready
    );
endinterface

FILE: hdl/gsc_core.sv
module gsc_core
    import gsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [GRACE_W-1:0] i_cfg_wdata,
    gsc_item_if.sink           i_item,
    input  logic               i_space,
    output t_push              o_push
);

    // input register
    logic               r_in_v;
    logic [1:0]         r_kind;
    logic [TAG_W-1:0]   r_rtag;
    logic [TAG_W-1:0]   r_ttag;
    logic               r_want;
    logic [COUNT_W-1:0] r_open;
    logic [TIME_W-1:0]  r_now;

    // controller state
    logic [GRACE_W-1:0] r_grace;
    logic               r_pending,  n_pending;
    logic [TAG_W-1:0]   r_ptag,     n_ptag;
    logic               r_pwant,    n_pwant;
    logic [TIME_W-1:0]  r_deadline, n_deadline;
    logic [TIME_W-1:0]  r_renotify, n_renotify;
    logic               r_forced,   n_forced;
    logic               r_hidden,   n_hidden;

    logic               proc;
    logic               two;
    logic [COUNT_W-1:0] clients;
    t_result            res0;
    t_result            res1;

    assign proc         = r_in_v & i_space;
    assign i_item.ready = ~r_in_v | i_space;
    assign clients      = (r_open == '0) ? '0 : r_open - COUNT_W'(1);

    always_comb begin
        n_pending  = r_pending;
        n_ptag     = r_ptag;
        n_pwant    = r_pwant;
        n_deadline = r_deadline;
        n_renotify = r_renotify;
        n_forced   = r_forced;
        n_hidden   = r_hidden;
        res0       = '0;
        res1       = '0;
        two        = 1'b0;

        case (t_kind'(r_kind))
            KIND_SHUTDOWN: begin
                if (r_pending) begin
                    res0.reply_valid = 1'b1;
                    res0.reply_tag   = r_rtag;
                    res0.reply_code  = CODE_IGNORED;
                end else begin
                    n_hidden        = 1'b1;
                    res0.send_break = 1'b1;
                    n_ptag          = r_rtag;
                    n_pwant         = r_want;
                    n_deadline      = r_now + clamp_grace(r_grace);
                    n_renotify      = r_now + RENOTIFY_SECS;
                    // fresh deadlines lie in the future, so only an empty client list finishes
                    n_pending       = (clients != '0);
                    if (clients == '0) begin
                        res0.reply_valid = 1'b1;
                        res0.reply_tag   = r_rtag;
                        res0.reply_code  = CODE_SUCCESS;
                        res0.go_down     = 1'b1;
                    end
                end
            end
            KIND_CANCEL: begin
                if (r_pending && r_ttag == r_ptag) begin
                    two              = 1'b1;
                    n_pending        = 1'b0;
                    n_forced         = 1'b0;
                    n_hidden         = 1'b0;
                    res0.reply_valid = 1'b1;
                    res0.reply_tag   = r_ptag;
                    res0.reply_code  = CODE_ABORTED;
                    res1.reply_valid = 1'b1;
                    res1.reply_tag   = r_rtag;
                    res1.reply_code  = CODE_SUCCESS;
                end else begin
                    res0.reply_valid = 1'b1;
                    res0.reply_tag   = r_rtag;
                    res0.reply_code  = CODE_NOT_FOUND;
                end
            end
            KIND_UNKNOWN: begin
                res0.reply_valid = 1'b1;
                res0.reply_tag   = r_rtag;
                res0.reply_code  = CODE_ABORTED;
            end
            KIND_TICK: begin
                if (r_pending) begin
                    if (clients == '0) begin
                        res0.reply_valid = 1'b1;
                        res0.reply_tag   = r_ptag;
                        res0.reply_code  = CODE_SUCCESS;
                        res0.go_down     = 1'b1;
                        n_pending        = 1'b0;
                    end else if (time_passed(r_now, r_deadline)) begin
                        res0.reply_valid = 1'b1;
                        res0.reply_tag   = r_ptag;
                        res0.reply_code  = CODE_SUCCESS;
                        res0.go_down     = 1'b1;
                        res0.count_valid = r_pwant;
                        res0.straggler_count = r_pwant ? clients : '0;
                        n_pending        = 1'b0;
                        n_forced         = 1'b1;
                    end else if (time_passed(r_now, r_renotify)) begin
                        res0.send_break  = 1'b1;
                        n_renotify       = r_now + RENOTIFY_SECS;
                    end
                end
            end
            default: begin
            end
        endcase

        res0.forced_flag     = n_forced;
        res0.request_pending = n_pending;
        res0.openers_blocked = n_hidden;
        res0.last            = ~two;
        res1.forced_flag     = n_forced;
        res1.request_pending = n_pending;
        res1.openers_blocked = n_hidden;
        res1.last            = 1'b1;
    end

    assign o_push.push0 = proc;
    assign o_push.push1 = proc & two;
    assign o_push.res0  = res0;
    assign o_push.res1  = res1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v     <= 1'b0;
            r_grace    <= GRACE_RESET;
            r_pending  <= 1'b0;
            r_ptag     <= '0;
            r_pwant    <= 1'b0;
            r_deadline <= '0;
            r_renotify <= '0;
            r_forced   <= 1'b0;
            r_hidden   <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_v <= i_item.valid;
            end
            if (i_cfg_we) begin
                r_grace <= i_cfg_wdata;
            end
            if (proc) begin
                r_pending  <= n_pending;
                r_ptag     <= n_ptag;
                r_pwant    <= n_pwant;
                r_deadline <= n_deadline;
                r_renotify <= n_renotify;
                r_forced   <= n_forced;
                r_hidden   <= n_hidden;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_kind <= i_item.kind;
            r_rtag <= i_item.request_tag;
            r_ttag <= i_item.target_tag;
            r_want <= i_item.want_count;
            r_open <= i_item.open_count;
            r_now  <= i_item.now_seconds;
        end
    end

endmodule

FILE: hdl/gsc_outq.sv
module gsc_outq
    import gsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_push       i_push,
    output logic        o_space,
    gsc_result_if.source o_result
);

    t_result    r_mem [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic [2:0] n_count;
    logic       pop;
    t_result    head;

    assign pop     = (r_count != 3'd0) & o_result.ready;
    assign o_space = (r_count <= 3'd2);
    assign n_count = r_count + {2'b0, i_push.push0} + {2'b0, i_push.push1} - {2'b0, pop};
    assign head    = r_mem[r_rd_ptr];

    assign o_result.valid           = (r_count != 3'd0);
    assign o_result.reply_valid     = head.reply_valid;
    assign o_result.reply_tag       = head.reply_tag;
    assign o_result.reply_code      = head.reply_code;
    assign o_result.count_valid     = head.count_valid;
    assign o_result.straggler_count = head.straggler_count;
    assign o_result.send_break      = head.send_break;
    assign o_result.go_down         = head.go_down;
    assign o_result.forced_flag     = head.forced_flag;
    assign o_result.request_pending = head.request_pending;
    assign o_result.openers_blocked = head.openers_blocked;
    assign o_result.last            = head.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_wr_ptr <= r_wr_ptr + {1'b0, i_push.push0} + {1'b0, i_push.push1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.push1) begin
            r_mem[r_wr_ptr + 2'd1] <= i_push.res1;
        end
    end

endmodule

FILE: hdl/graceful_shutdown_controller.sv
// Graceful shutdown controller.
// i_item carries messages (shutdown request, cancel, unknown command) and
// time ticks; o_result carries one result per item, two for a cancel that
// recalls the pending request (the final one has last set). Both channels
// move an item when valid and ready are high at a rising edge.
// i_cfg_we / i_cfg_wdata write the grace period register (seconds, clamped
// to 1..60 when a request begins); write it only while the block is idle.
// An accepted item is held in the input register until the queue has room
// for two, then decided, written into the queue and offered on o_result.
// Throughput: one item per cycle while the output queue has room for two.
// Results wait in a four-entry output queue; the input register is decided
// only while the queue has room for two, so a stalled receiver backs up
// into i_item.ready after at most a few items without loss.
// Reset (synchronous, active low) clears the queue, all controller state,
// and sets the grace period to 4 seconds.
module graceful_shutdown_controller
    import gsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [GRACE_W-1:0] i_cfg_wdata,
    gsc_item_if.sink           i_item,
    gsc_result_if.source       o_result
);

    t_push push;
    logic  space;

    gsc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .i_space     (space),
        .o_push      (push)
    );

    gsc_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_space  (space),
        .o_result (o_result)
    );

endmodule
